// ----- hw/rtl/min_max_heap_queue_macros.svh -----
// Assertion helpers shared by the checker
`ifndef MIN_MAX_HEAP_QUEUE_MACROS_SVH
`define MIN_MAX_HEAP_QUEUE_MACROS_SVH

// property sampled on clk_i, ignored while rst_ni is low
`define MMHQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// pre in one cycle implies post in the next
`define MMHQ_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- hw/rtl/mmhq_pkg.sv -----
`default_nettype none
package mmhq_pkg;

  localparam int unsigned KeyW   = 32;
  localparam int unsigned CountW = 11;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_EXT_MIN = 2'd1,
    OP_EXT_MAX = 2'd2,
    OP_CLEAR   = 2'd3
  } mmhq_op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } mmhq_status_e;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_RD2, S_RD3, S_SEL, S_RDS, S_CAPS, S_RDL, S_CAPL,
    S_SKTOP, S_SKRD, S_SKCMP, S_SKEVAL, S_SKRP, S_SKCP, S_WKI,
    S_RSTOP, S_RSCP, S_RSCG, S_F1, S_F2, S_F3, S_F4, S_DONE
  } mmhq_state_e;

  typedef enum logic [4:0] {
    C_NOP, C_ACCEPT, C_DISPATCH, C_RD2, C_RD3, C_SEL, C_RDS, C_CAPS, C_RDL, C_CAPL,
    C_SKTOP, C_SKRD, C_SKCMP, C_SKEVAL, C_SKRP, C_SKCP, C_WKI,
    C_RSTOP, C_RSCP, C_RSCG, C_F1, C_F2, C_F3, C_F4, C_LOAD
  } mmhq_cmd_e;

  typedef struct packed {
    mmhq_cmd_e cmd;
    logic      idle;
  } mmhq_ctl_t;

  typedef struct packed {
    mmhq_op_e op;
    logic     fill_zero;
    logic     fill_one;
    logic     fill_two;
    logic     fill_full;
    logic     idx_one;
    logic     idx_gt3;
    logic     slot_last;
    logic     sk_full;
    logic     sk_leaf;
    logic     cand_end;
    logic     swap_p;
    logic     swap_g;
    logic     beat_best;
    logic     best_wins;
    logic     best_gc;
    logic     cp_swap;
    logic     full_walk;
    logic     out_free;
  } mmhq_sts_t;

  // a strictly ahead of b on a max level (mx) or a min level
  function automatic logic ranks_before(input logic [KeyW-1:0] a,
                                        input logic [KeyW-1:0] b,
                                        input logic mx);
    ranks_before = mx ? (a > b) : (a < b);
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/mmhq_ram.sv -----
`default_nettype none
module mmhq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1025
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// ----- hw/rtl/mmhq_ctrl.sv -----
`default_nettype none
module mmhq_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire mmhq_pkg::mmhq_sts_t sts_i,
  output mmhq_pkg::mmhq_ctl_t     ctl_o
);
  import mmhq_pkg::*;

  mmhq_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:     if (in_valid_i) state_d = S_DISPATCH;
      S_DISPATCH: begin
        case (sts_i.op)
          OP_INSERT:  state_d = sts_i.fill_full ? S_F1 : S_RSTOP;
          OP_EXT_MIN: state_d = sts_i.fill_zero ? S_F1 : S_RDS;
          OP_EXT_MAX: begin
            if (sts_i.fill_zero) state_d = S_F1;
            else if (sts_i.fill_one || sts_i.fill_two) state_d = S_RDS;
            else state_d = S_RD2;
          end
          default:    state_d = S_F1;
        endcase
      end
      S_RD2:    state_d = S_RD3;
      S_RD3:    state_d = S_SEL;
      S_SEL:    state_d = S_RDL;
      S_RDS:    state_d = S_CAPS;
      S_CAPS:   state_d = S_RDL;
      S_RDL:    state_d = S_CAPL;
      S_CAPL:   state_d = sts_i.slot_last ? S_F1 : S_SKTOP;
      S_SKTOP: begin
        if (sts_i.sk_full) state_d = S_SKRD;
        else if (sts_i.sk_leaf) state_d = S_WKI;
        else state_d = S_SKRD;
      end
      S_SKRD:   state_d = sts_i.cand_end ? S_SKEVAL : S_SKCMP;
      S_SKCMP:  state_d = S_SKRD;
      S_SKEVAL: begin
        if (sts_i.full_walk) begin
          state_d = sts_i.beat_best ? S_WKI : S_SKRP;
        end else if (sts_i.best_wins && sts_i.best_gc) begin
          state_d = S_SKRP;
        end else begin
          state_d = S_WKI;
        end
      end
      S_SKRP:   state_d = S_SKCP;
      S_SKCP:   state_d = sts_i.full_walk ? S_SKTOP : S_WKI;
      S_WKI:    state_d = S_F1;
      S_RSTOP:  state_d = sts_i.idx_one ? S_WKI : S_RSCP;
      S_RSCP: begin
        if (sts_i.swap_p) state_d = S_RSTOP;
        else if (sts_i.idx_gt3) state_d = S_RSCG;
        else state_d = S_WKI;
      end
      S_RSCG:   state_d = sts_i.swap_g ? S_RSTOP : S_WKI;
      S_F1:     state_d = sts_i.fill_zero ? S_DONE : S_F2;
      S_F2:     state_d = sts_i.fill_one ? S_DONE : S_F3;
      S_F3:     state_d = sts_i.fill_two ? S_DONE : S_F4;
      S_F4:     state_d = S_DONE;
      S_DONE:   if (sts_i.out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctl_o.idle = (state_q == S_IDLE);
    case (state_q)
      S_IDLE:     ctl_o.cmd = in_valid_i ? C_ACCEPT : C_NOP;
      S_DISPATCH: ctl_o.cmd = C_DISPATCH;
      S_RD2:      ctl_o.cmd = C_RD2;
      S_RD3:      ctl_o.cmd = C_RD3;
      S_SEL:      ctl_o.cmd = C_SEL;
      S_RDS:      ctl_o.cmd = C_RDS;
      S_CAPS:     ctl_o.cmd = C_CAPS;
      S_RDL:      ctl_o.cmd = C_RDL;
      S_CAPL:     ctl_o.cmd = C_CAPL;
      S_SKTOP:    ctl_o.cmd = C_SKTOP;
      S_SKRD:     ctl_o.cmd = C_SKRD;
      S_SKCMP:    ctl_o.cmd = C_SKCMP;
      S_SKEVAL:   ctl_o.cmd = C_SKEVAL;
      S_SKRP:     ctl_o.cmd = C_SKRP;
      S_SKCP:     ctl_o.cmd = C_SKCP;
      S_WKI:      ctl_o.cmd = C_WKI;
      S_RSTOP:    ctl_o.cmd = C_RSTOP;
      S_RSCP:     ctl_o.cmd = C_RSCP;
      S_RSCG:     ctl_o.cmd = C_RSCG;
      S_F1:       ctl_o.cmd = C_F1;
      S_F2:       ctl_o.cmd = C_F2;
      S_F3:       ctl_o.cmd = C_F3;
      S_F4:       ctl_o.cmd = C_F4;
      S_DONE:     ctl_o.cmd = sts_i.out_free ? C_LOAD : C_NOP;
      default:    ctl_o.cmd = C_NOP;
    endcase
  end
endmodule
`default_nettype wire

// ----- hw/rtl/mmhq_dp.sv -----
`default_nettype none
module mmhq_dp #(
  parameter int unsigned CAPACITY = 1024
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire mmhq_pkg::mmhq_ctl_t    ctl_i,
  output mmhq_pkg::mmhq_sts_t         sts_o,
  input  wire logic [1:0]             opcode_i,
  input  wire logic [31:0]            key_in_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic [31:0]                 key_out_o,
  output logic [1:0]                  status_o,
  output logic [10:0]                 entry_count_o,
  output logic [31:0]                 smallest_o,
  output logic [31:0]                 largest_o
);
  import mmhq_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = AW + 3;

  logic [AW-1:0]   fill_q, idx_q, best_q;
  logic [KeyW-1:0] key_q, kin_q, bestval_q, v2_q, kout_q, min_q, max_q;
  logic            mx_q, have_q, full_q, out_valid_q;
  logic [2:0]      cand_q;
  mmhq_op_e        op_q;
  mmhq_status_e    st_q;

  logic [KeyW-1:0] okey_q, omin_q, omax_q;
  logic [1:0]      ost_q;
  logic [10:0]     ocnt_q;

  logic [KeyW-1:0] rd_data;
  logic [AW-1:0]   rd_addr, wr_addr;
  logic [KeyW-1:0] wr_data;
  logic            wr_en;

  logic [IW-1:0]   idx_w, n_w, first_w, child_w, cand_w;
  logic [AW-1:0]   cand_addr, ins_idx;
  logic            ins_par, out_free;
  logic [AW+10:0]  cnt_ext;

  assign idx_w   = IW'(idx_q);
  assign n_w     = IW'(fill_q);
  assign first_w = idx_w << 2;
  assign child_w = idx_w << 1;
  assign cand_w  = (cand_q < 3'd2) ? child_w + IW'(cand_q) : first_w + IW'(cand_q - 3'd2);
  assign cand_addr = cand_w[AW-1:0];
  assign ins_idx = fill_q + AW'(1);
  assign out_free = !out_valid_q || !out_stall_i;

  // depth parity of the new slot: position of its top set bit
  always_comb begin
    ins_par = 1'b0;
    for (int i = 0; i < AW; i++) begin
      if (ins_idx[i]) ins_par = i[0];
    end
  end

  always_comb begin
    sts_o.op        = op_q;
    sts_o.fill_zero = (fill_q == '0);
    sts_o.fill_one  = (fill_q == AW'(1));
    sts_o.fill_two  = (fill_q == AW'(2));
    sts_o.fill_full = (fill_q >= AW'(CAPACITY));
    sts_o.idx_one   = (idx_q == AW'(1));
    sts_o.idx_gt3   = (idx_q > AW'(3));
    sts_o.slot_last = (idx_q == fill_q);
    sts_o.sk_full   = (first_w + IW'(3) <= n_w);
    sts_o.sk_leaf   = (child_w > n_w);
    sts_o.cand_end  = (cand_q > (full_q ? 3'd5 : 3'd4)) || (cand_w > n_w);
    sts_o.swap_p    = ranks_before(key_q, rd_data, !mx_q);
    sts_o.swap_g    = ranks_before(key_q, rd_data, mx_q);
    sts_o.beat_best = ranks_before(key_q, bestval_q, mx_q);
    sts_o.best_wins = ranks_before(bestval_q, key_q, mx_q);
    sts_o.best_gc   = (IW'(best_q) >= first_w);
    sts_o.cp_swap   = ranks_before(rd_data, key_q, mx_q);
    sts_o.full_walk = full_q;
    sts_o.out_free  = out_free;
  end

  always_comb begin
    case (ctl_i.cmd)
      C_RD2, C_F2: rd_addr = AW'(2);
      C_RD3, C_F3: rd_addr = AW'(3);
      C_F1:        rd_addr = AW'(1);
      C_RDL:       rd_addr = fill_q;
      C_SKRD:      rd_addr = cand_addr;
      C_SKRP:      rd_addr = best_q >> 1;
      C_RSTOP:     rd_addr = idx_q >> 1;
      C_RSCP:      rd_addr = idx_q >> 2;
      default:     rd_addr = idx_q;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_q;
    wr_data = key_q;
    case (ctl_i.cmd)
      C_SKEVAL: begin
        wr_en   = full_q ? !sts_o.beat_best : sts_o.best_wins;
        wr_data = bestval_q;
      end
      C_SKCP: begin
        wr_en   = sts_o.cp_swap;
        wr_addr = best_q >> 1;
      end
      C_WKI:  wr_en = 1'b1;
      C_RSCP: begin
        wr_en   = sts_o.swap_p;
        wr_data = rd_data;
      end
      C_RSCG: begin
        wr_en   = sts_o.swap_g;
        wr_data = rd_data;
      end
      default: wr_en = 1'b0;
    endcase
  end

  mmhq_ram #(
    .WIDTH(KeyW),
    .DEPTH(CAPACITY + 1)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_addr),
    .wdata_i(wr_data),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctl_i.cmd == C_DISPATCH) begin
        if (op_q == OP_CLEAR) fill_q <= '0;
        else if (op_q == OP_INSERT && !sts_o.fill_full) fill_q <= ins_idx;
      end else if (ctl_i.cmd == C_CAPL) begin
        fill_q <= fill_q - AW'(1);
      end
      if (ctl_i.cmd == C_LOAD) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  assign cnt_ext = {11'd0, fill_q};

  always_ff @(posedge clk_i) begin
    case (ctl_i.cmd)
      C_ACCEPT: begin
        op_q   <= mmhq_op_e'(opcode_i);
        kin_q  <= key_in_i;
        kout_q <= '0;
        st_q   <= ST_OK;
      end
      C_DISPATCH: begin
        case (op_q)
          OP_INSERT: begin
            if (sts_o.fill_full) begin
              st_q <= ST_FULL;
            end else begin
              idx_q <= ins_idx;
              key_q <= kin_q;
              mx_q  <= ins_par;
            end
          end
          OP_EXT_MIN, OP_EXT_MAX: begin
            if (sts_o.fill_zero) begin
              kout_q <= '1;
              st_q   <= ST_EMPTY;
            end else if (op_q == OP_EXT_MAX && sts_o.fill_two) begin
              idx_q <= AW'(2);
              mx_q  <= 1'b1;
            end else begin
              idx_q <= AW'(1);
              mx_q  <= 1'b0;
            end
          end
          default: st_q <= ST_OK;
        endcase
      end
      C_RD3: v2_q <= rd_data;
      C_SEL: begin
        mx_q <= 1'b1;
        if (v2_q > rd_data) begin
          idx_q  <= AW'(2);
          kout_q <= v2_q;
        end else begin
          idx_q  <= AW'(3);
          kout_q <= rd_data;
        end
      end
      C_CAPS: kout_q <= rd_data;
      C_CAPL: key_q  <= rd_data;
      C_SKTOP: begin
        cand_q <= sts_o.sk_full ? 3'd2 : 3'd0;
        have_q <= 1'b0;
        full_q <= sts_o.sk_full;
      end
      C_SKCMP: begin
        if (!have_q || ranks_before(rd_data, bestval_q, mx_q)) begin
          best_q    <= cand_addr;
          bestval_q <= rd_data;
          have_q    <= 1'b1;
        end
        cand_q <= cand_q + 3'd1;
      end
      C_SKEVAL: begin
        // moved into a child: key settles in the child's old slot
        if (!full_q && sts_o.best_wins && !sts_o.best_gc) idx_q <= best_q;
      end
      C_SKCP: begin
        if (sts_o.cp_swap) key_q <= rd_data;
        idx_q <= best_q;
      end
      C_RSCP: begin
        if (sts_o.swap_p) begin
          idx_q <= idx_q >> 1;
          mx_q  <= !mx_q;
        end
      end
      C_RSCG: if (sts_o.swap_g) idx_q <= idx_q >> 2;
      C_F1: begin
        if (sts_o.fill_zero) begin
          min_q <= '0;
          max_q <= '0;
        end
      end
      C_F2: begin
        min_q <= rd_data;
        if (sts_o.fill_one) max_q <= rd_data;
      end
      C_F3: begin
        v2_q <= rd_data;
        if (sts_o.fill_two) max_q <= rd_data;
      end
      C_F4: max_q <= (v2_q > rd_data) ? v2_q : rd_data;
      C_LOAD: begin
        okey_q <= kout_q;
        ost_q  <= st_q;
        ocnt_q <= cnt_ext[10:0];
        omin_q <= min_q;
        omax_q <= max_q;
      end
      default: have_q <= have_q;
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign key_out_o     = okey_q;
  assign status_o      = ost_q;
  assign entry_count_o = ocnt_q;
  assign smallest_o    = omin_q;
  assign largest_o     = omax_q;
endmodule
`default_nettype wire

// ----- hw/rtl/min_max_heap_queue.sv -----
// Min-max heap double-ended priority queue of 32-bit keys.
// Input channel (in_valid_i / in_stall_o): opcode_i and key_in_i, one
// operation per transfer: insert, extract smallest, extract largest, clear.
// Output channel (out_valid_o / out_stall_i): one result per operation with
// the extracted key, status, entry count and the smallest and largest keys.
// Keys live in a RAM with one read port and one write port; every heap step
// is at most one RAM read and one write per cycle, so the item time is set
// by those ports. An insert climbs by parent and grandparent steps; an
// extract walks down by grandchild steps, with a last step among children
// and grandchildren. The next transfer can be taken in the cycle after the
// result is loaded.
// One item is worked at a time; in_stall_o is high from acceptance until the
// result has been moved into the output register.
// The output register holds a result while out_stall_i is high; the next
// item is accepted meanwhile and its result waits until the register frees.
// Reset empties the queue at once (count to zero); RAM contents are not
// cleared and are never used beyond the count.
`default_nettype none
module min_max_heap_queue #(
  parameter int unsigned CAPACITY = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [31:0] key_in_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      key_out_o,
  output logic [1:0]       status_o,
  output logic [10:0]      entry_count_o,
  output logic [31:0]      smallest_o,
  output logic [31:0]      largest_o
);
  import mmhq_pkg::*;

  mmhq_ctl_t ctl;
  mmhq_sts_t sts;

  assign in_stall_o = !ctl.idle;

  mmhq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .sts_i     (sts),
    .ctl_o     (ctl)
  );

  mmhq_dp #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .sts_o        (sts),
    .opcode_i     (opcode_i),
    .key_in_i     (key_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .key_out_o    (key_out_o),
    .status_o     (status_o),
    .entry_count_o(entry_count_o),
    .smallest_o   (smallest_o),
    .largest_o    (largest_o)
  );
endmodule
`default_nettype wire

// ----- hw/rtl/mmhq_checker.sv -----
`default_nettype none
`include "min_max_heap_queue_macros.svh"
module mmhq_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic [1:0]  opcode_i,
  input wire logic [31:0] key_in_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [31:0] key_out_o,
  input wire logic [1:0]  status_o,
  input wire logic [10:0] entry_count_o,
  input wire logic [31:0] smallest_o,
  input wire logic [31:0] largest_o
);
  import mmhq_pkg::*;

  `MMHQ_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(key_out_o) && $stable(entry_count_o), "stalled result changed")
  `MMHQ_ASSERT_NEXT(a_busy_after_take, in_valid_i && !in_stall_o, in_stall_o, "second transfer taken while busy")
  `MMHQ_ASSERT(a_order, !(out_valid_o && entry_count_o != 11'd0) || smallest_o <= largest_o, "smallest above largest")
  `MMHQ_ASSERT(a_empty, !(out_valid_o && status_o == ST_EMPTY) || (key_out_o == '1 && entry_count_o == 11'd0), "bad empty result")
endmodule

bind min_max_heap_queue mmhq_checker u_mmhq_checker (.*);
`default_nettype wire
